// ===== hw/rtl/char_lcd_nibble_write_sequencer_macros.svh =====
// assertion helpers shared by the sequencer modules
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CLNWS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lcd sequencer check failed");

// next-cycle implication, checked out of reset
`define CLNWS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lcd sequencer check failed");

`endif

// ===== hw/rtl/clnws_pkg.sv =====
package clnws_pkg;

  localparam int CFG_W       = 10;
  localparam int HOLD_W      = 14;
  localparam int INIT_STEPS  = 10;
  localparam int STEP_W      = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_W-1:0]  STROBE_HOLD_RST = 10'd100;
  localparam logic [HOLD_W-1:0] IDLE_HOLD_US    = 14'd100;
  localparam logic [HOLD_W-1:0] POWER_UP_US     = 14'd15000;

  // request codes
  typedef enum logic [2:0] {
    OP_COMMAND  = 3'd0,
    OP_CHAR     = 3'd1,
    OP_CURSOR   = 3'd2,
    OP_CHAR_AT  = 3'd3,
    OP_INIT     = 3'd4
  } op_e;

  // one queued job: a full byte transfer or a single idle segment
  typedef struct packed {
    logic              idle;
    logic              rs;
    logic [7:0]        data;
    logic [HOLD_W-1:0] trail;
    logic              last;
  } job_t;

  // one pin segment as shown on the result ports
  typedef struct packed {
    logic              reg_select;
    logic              enable;
    logic [3:0]        nibble;
    logic              drive;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } seg_t;

  // display line start addresses, line 1 at index 0
  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  // power-up command bytes
  function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0, 4'd1: b = 8'h30;
      4'd2: b = 8'h32;
      4'd3: b = 8'h2B;
      4'd4: b = 8'h08;
      4'd5, 4'd8: b = 8'h0F;
      4'd6: b = 8'h01;
      4'd7: b = 8'h06;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  // delay after each power-up command
  function automatic logic [HOLD_W-1:0] init_delay(input logic [STEP_W-1:0] idx);
    logic [HOLD_W-1:0] d;
    unique case (idx)
      4'd0: d = 14'd5000;
      4'd2: d = 14'd200;
      default: d = 14'd100;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_write_sequencer.sv =====
// 4-bit character LCD write sequencer.
// Request channel: a request (op, byte_value, row, column) is taken at a
// rising edge with start high and busy low. Ops: command byte, character byte,
// cursor move, character at position, power-up initialisation.
// Result channel: each pin segment (reg_select, enable, nibble, drive,
// hold_us, last) is shown for exactly one cycle with strobe high; last marks
// the final segment of a request. The receiver cannot stall this channel.
// Path: request register, job queue, job register, output word register.
// Throughput: the segment sequencer emits one segment per cycle while jobs
// are queued; a byte transfer is five segments and initialisation 51. The
// request decoder queues one job per cycle into a 4-entry job queue while
// it is not full, so busy only rises for a multi-job request or a full queue.
// Codes 5 to 7 are taken and produce no segments.
// Config: APB register 0 (strobe_hold_us, reset 100) at byte address 0;
// write it only while no segments are pending.
// Reset clears the queue and sequencer and restores strobe_hold_us.
module char_lcd_nibble_write_sequencer import clnws_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        op,
  input  logic [7:0]        byte_value,
  input  logic [7:0]        row,
  input  logic [7:0]        column,
  // segment channel
  output logic              strobe,
  output logic              reg_select,
  output logic              enable,
  output logic [3:0]        nibble,
  output logic              drive,
  output logic [HOLD_W-1:0] hold_us,
  output logic              last,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic             cfg_wr;
  logic             reg0_sel;
  logic [CFG_W-1:0] strobe_hold_us;
  logic             push;
  logic             full;
  job_t             push_job;
  logic             q_valid;
  job_t             q_job;
  logic             pop;
  seg_t             seg;

  // register file: word index in paddr[2], byte offset ignored
  assign pready   = 1'b1;
  assign reg0_sel = (paddr[2] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = reg0_sel ? {{(32-CFG_W){1'b0}}, strobe_hold_us} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_hold_us <= STROBE_HOLD_RST;
    end else if (cfg_wr && reg0_sel) begin
      strobe_hold_us <= pwdata[CFG_W-1:0];
    end
  end

  clnws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .busy       (busy),
    .push       (push),
    .job        (push_job),
    .full       (full)
  );

  clnws_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (q_job)
  );

  clnws_back u_back (
    .clk            (clk),
    .rst            (rst),
    .strobe_hold_us (strobe_hold_us),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .pop            (pop),
    .seg_valid      (strobe),
    .seg            (seg)
  );

  // segment word onto the pins
  assign reg_select = seg.reg_select;
  assign enable     = seg.enable;
  assign nibble     = seg.nibble;
  assign drive      = seg.drive;
  assign hold_us    = seg.hold_us;
  assign last       = seg.last;

endmodule

// ===== hw/rtl/clnws_front.sv =====
module clnws_front import clnws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] op,
  input  logic [7:0] byte_value,
  input  logic [7:0] row,
  input  logic [7:0] column,
  output logic       busy,
  output logic       push,
  output job_t       job,
  input  logic       full
);

  `include "char_lcd_nibble_write_sequencer_macros.svh"

  logic              active;
  logic [2:0]        req_op;
  logic [7:0]        req_byte;
  logic [7:0]        req_row;
  logic [7:0]        req_col;
  logic [STEP_W-1:0] step;
  logic              fin;
  logic              accept;
  logic              row_ok;
  logic [7:0]        cursor_cmd;
  logic [1:0]        base_idx;
  logic [STEP_W-1:0] init_idx;
  job_t              cursor_job;

  // cursor address command or idle segment for a bad line
  always_comb begin
    row_ok     = (req_row >= 8'd1) && (req_row <= 8'd4);
    base_idx   = 2'(req_row - 8'd1);
    cursor_cmd = row_base(base_idx) + req_col - 8'd1;
    cursor_job = '0;
    cursor_job.idle  = !row_ok;
    cursor_job.data  = row_ok ? cursor_cmd : 8'h00;
    cursor_job.trail = IDLE_HOLD_US;
  end

  // job for the current step of the held request
  always_comb begin
    job      = '0;
    fin      = 1'b1;
    init_idx = step - 4'd1;
    unique case (req_op)
      OP_COMMAND: begin
        job.data = req_byte;
      end
      OP_CHAR: begin
        job.rs   = 1'b1;
        job.data = req_byte;
      end
      OP_CURSOR: begin
        job = cursor_job;
      end
      OP_CHAR_AT: begin
        if (step == '0) begin
          job = cursor_job;
          fin = 1'b0;
        end else begin
          job.rs   = 1'b1;
          job.data = req_byte;
        end
      end
      OP_INIT: begin
        if (step == '0) begin
          job.idle  = 1'b1;
          job.trail = POWER_UP_US;
        end else begin
          job.data  = init_byte(init_idx);
          job.trail = init_delay(init_idx);
        end
        fin = (step == STEP_W'(INIT_STEPS));
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    job.last = fin;
  end

  assign push   = active && !full;
  assign busy   = active && !(push && fin);
  assign accept = start && !busy;

  // request holding register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (accept) begin
      active <= (op <= OP_INIT);
      step   <= '0;
    end else if (push) begin
      if (fin) begin
        active <= 1'b0;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= op;
      req_byte <= byte_value;
      req_row  <= row;
      req_col  <= column;
    end
  end

  `CLNWS_ASSERT_NXT(a_accept_arms, clk, rst, accept && (op <= OP_INIT), active && (step == '0))
  `CLNWS_ASSERT_IMP(a_step_range, clk, rst, active, step <= STEP_W'(INIT_STEPS))

endmodule

// ===== hw/rtl/clnws_fifo.sv =====
module clnws_fifo import clnws_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  `include "char_lcd_nibble_write_sequencer_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CLNWS_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
  `CLNWS_ASSERT_IMP(a_no_underflow, clk, rst, pop, valid)
  `CLNWS_ASSERT_NXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== hw/rtl/clnws_back.sv =====
module clnws_back import clnws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] strobe_hold_us,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             pop,
  output logic             seg_valid,
  output seg_t             seg
);

  `include "char_lcd_nibble_write_sequencer_macros.svh"

  // segment of a byte transfer
  typedef enum logic [4:0] {
    SEG_CLEAR      = 5'b00001,
    SEG_HIGH       = 5'b00010,
    SEG_LOW_SETUP  = 5'b00100,
    SEG_LOW_STROBE = 5'b01000,
    SEG_RELEASE    = 5'b10000
  } phase_t;

  logic              active;
  job_t              cur;
  phase_t            phase;
  phase_t            phase_next;
  logic              done;
  logic [HOLD_W-1:0] strobe_hold;
  seg_t              seg_next;

  assign strobe_hold = HOLD_W'(strobe_hold_us);
  assign done        = active && (cur.idle || (phase == SEG_RELEASE));
  assign pop         = q_valid && (!active || done);

  // segment order
  always_comb begin
    unique case (phase)
      SEG_CLEAR:      phase_next = SEG_HIGH;
      SEG_HIGH:       phase_next = SEG_LOW_SETUP;
      SEG_LOW_SETUP:  phase_next = SEG_LOW_STROBE;
      SEG_LOW_STROBE: phase_next = SEG_RELEASE;
      default:        phase_next = SEG_CLEAR;
    endcase
  end

  // pin levels for the current segment
  always_comb begin
    seg_next            = '0;
    seg_next.reg_select = cur.rs;
    seg_next.last       = cur.last && done;
    if (cur.idle) begin
      seg_next.reg_select = 1'b0;
      seg_next.hold_us    = cur.trail;
    end else begin
      unique case (phase)
        SEG_CLEAR: begin
          seg_next.drive   = 1'b1;
          seg_next.hold_us = strobe_hold;
        end
        SEG_HIGH: begin
          seg_next.enable  = 1'b1;
          seg_next.nibble  = cur.data[7:4];
          seg_next.drive   = 1'b1;
          seg_next.hold_us = strobe_hold;
        end
        SEG_LOW_SETUP: begin
          seg_next.nibble  = cur.data[3:0];
          seg_next.drive   = 1'b1;
        end
        SEG_LOW_STROBE: begin
          seg_next.enable  = 1'b1;
          seg_next.nibble  = cur.data[3:0];
          seg_next.drive   = 1'b1;
          seg_next.hold_us = strobe_hold;
        end
        default: begin
          seg_next.hold_us = cur.trail;
        end
      endcase
    end
  end

  // job register and segment sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= SEG_CLEAR;
    end else if (pop) begin
      active <= 1'b1;
      phase  <= SEG_CLEAR;
    end else if (done) begin
      active <= 1'b0;
      phase  <= SEG_CLEAR;
    end else if (active) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
  end

  `CLNWS_ASSERT_NXT(a_pop_starts, clk, rst, pop, active && (phase == SEG_CLEAR))
  `CLNWS_ASSERT_IMP(a_phase_byte, clk, rst, phase != SEG_CLEAR, active && !cur.idle)
  `CLNWS_ASSERT_IMP(a_enable_drives, clk, rst, seg_valid && seg.enable, seg.drive)

endmodule
